[rtl/hsa_pkg.sv]
// Shared types, sizes, codes and helper functions of the handle slot allocator.
package hsa_pkg;

   // Floor of log2, for elaboration-time sizing
   function automatic int floor_log2(input longint value);
      int result;
      result = 0;
      for (int k = 1; k < 40; k++) begin
         if ((longint'(1) << k) <= value) result = k;
      end
      return result;
   endfunction

   localparam int MAX_SLOTS     = 4096;
   localparam int INITIAL_SLOTS = 4;
   localparam int HANDLE_BITS   = 24;
   localparam int CONTEXT_BITS  = 16;

   // Slot store geometry: the store is the largest power of two within MAX_SLOTS
   localparam int MAX_LOG2   = floor_log2(longint'(MAX_SLOTS));
   localparam int SLOT_W     = MAX_LOG2;
   localparam int SLOTS      = 1 << MAX_LOG2;
   localparam int LIMIT_LOG2 = (MAX_LOG2 < HANDLE_BITS) ? MAX_LOG2 : HANDLE_BITS;
   localparam int LOG_W      = $clog2(SLOT_W + 1);
   localparam int CNT_W      = SLOT_W + 1;
   localparam int NEXT_W     = HANDLE_BITS + 1;

   // Start-up size: initial slots rounded down, capped by store and handle space
   function automatic int initial_log2();
      int lg;
      longint sz;
      lg = 0;
      for (int k = 0; k < 20; k++) begin
         sz = longint'(1) << (k + 1);
         if (sz <= longint'(INITIAL_SLOTS) && sz <= longint'(MAX_SLOTS) &&
             sz <= (longint'(1) << HANDLE_BITS)) lg = k + 1;
      end
      return lg;
   endfunction

   localparam int INIT_LOG2 = initial_log2();

   // Result status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   // One slot of the store
   typedef struct packed {
      logic                    valid;
      logic [31:0]             handle;
      logic [CONTEXT_BITS-1:0] ctx;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      RD_PROBE  = 2'd0,
      RD_LOOKUP = 2'd1,
      RD_GROW   = 2'd2
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_ZERO  = 2'd0,
      WR_STORE = 2'd1,
      WR_MOVE  = 2'd2
   } wr_sel_type;

   typedef enum logic [1:0] {
      RES_NONE   = 2'd0,
      RES_ISSUED = 2'd1,
      RES_LOOKUP = 2'd2,
      RES_FULL   = 2'd3
   } res_type;

   // Controller to datapath
   typedef struct packed {
      logic       load_item;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       cand_next;
      logic       idx_clr;
      logic       idx_inc;
      logic       grow_size;
      res_type    res_kind;
      logic       out_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic op_lookup;
      logic count_full;
      logic grow_ok;
      logic slot_free;
      logic move_bit;
      logic idx_last_grow;
      logic idx_last_clear;
      logic out_free;
   } status_type;

endpackage

[rtl/handle_slot_allocator.sv]
// Top level of the handle slot allocator: controller, datapath and register port.
//
// After reset the block zeroes every slot of its store and stalls
// the request channel meanwhile; harbor writes are taken at any time. A
// lookup then reads the slot its handle selects and passes the result on
// to the output register (one store read and compare). A registration
// reads the first slot probed and, while it is occupied, goes on to the
// next handle; each probe is one read of the slot store followed by a check.
// When the table is full and may still grow, a doubling pass first walks
// every slot of the old size; a slot that stays is read and checked, and a
// slot that moves to the upper half is also copied there and cleared. One
// item is worked on at a time; the next one is accepted while a finished
// result still waits in the output register.
module handle_slot_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [15:0] req_context_id,
   input  logic [31:0] req_handle,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_issued_handle,
   output logic [15:0] rsp_found_context,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_harbor
);

   hsa_pkg::cmd_type    cmd;
   hsa_pkg::status_type status;

   // Harbor register is always writable
   assign csr_ready = 1'b1;

   hsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   hsa_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_operation     (req_operation),
      .req_context_id    (req_context_id),
      .req_handle        (req_handle),
      .harbor_we         (csr_valid && csr_ready),
      .csr_harbor        (csr_harbor),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_issued_handle (rsp_issued_handle),
      .rsp_found_context (rsp_found_context)
   );

   // An accepted item keeps the request side stalled until it is done
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while an item is still in work");

   // A result is only loaded into a free output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("pending result overwritten");

   // A new result appears only through a load
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.out_load))
      else $error("result shown without a load");

   // Store write and item capture never coincide
   a_no_write_on_capture: assert property (@(posedge clock) disable iff (reset)
      cmd.load_item |-> !cmd.wr_en && !cmd.out_load)
      else $error("store written while an item is captured");

endmodule

[rtl/hsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module hsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/hsa_datapath.sv]
// Datapath: item registers, table size and index state, slot store and result registers.
module hsa_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  hsa_pkg::cmd_type           cmd,
   output hsa_pkg::status_type        status,
   input  logic                       req_operation,
   input  logic [15:0]                req_context_id,
   input  logic [31:0]                req_handle,
   input  logic                       harbor_we,
   input  logic [31:0]                csr_harbor,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_status,
   output logic [31:0]                rsp_issued_handle,
   output logic [15:0]                rsp_found_context
);

   // Control state
   logic [31:0]                  harbor_ff, harbor_in;
   logic [hsa_pkg::LOG_W-1:0]    size_log2_ff, size_log2_in;
   logic [hsa_pkg::NEXT_W-1:0]   next_index_ff, next_index_in;
   logic [hsa_pkg::CNT_W-1:0]    entry_count_ff, entry_count_in;
   logic [hsa_pkg::SLOT_W-1:0]   idx_ff, idx_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // Payload
   logic                            op_ff, op_in;
   logic [15:0]                     ctx_ff, ctx_in;
   logic [31:0]                     key_ff, key_in;
   logic [hsa_pkg::HANDLE_BITS-1:0] cand_ff, cand_in;
   logic [1:0]                      res_status_ff, res_status_in;
   logic [31:0]                     res_handle_ff, res_handle_in;
   logic [15:0]                     res_ctx_ff, res_ctx_in;
   logic [1:0]                      rsp_status_ff, rsp_status_in;
   logic [31:0]                     rsp_handle_ff, rsp_handle_in;
   logic [15:0]                     rsp_ctx_ff, rsp_ctx_in;

   // Slot store ports
   logic                          ram_wr_en;
   logic [hsa_pkg::SLOT_W-1:0]    ram_wr_addr;
   hsa_pkg::entry_type            ram_wr_entry;
   logic [hsa_pkg::SLOT_W-1:0]    ram_rd_addr;
   logic [hsa_pkg::ENTRY_W-1:0]   ram_rd_data;
   hsa_pkg::entry_type            rd_entry;

   // Derived values
   logic [hsa_pkg::SLOT_W-1:0]    size_mask;
   logic [hsa_pkg::CNT_W-1:0]     size_cnt;
   logic [hsa_pkg::SLOT_W-1:0]    probe_slot;
   logic [hsa_pkg::SLOT_W-1:0]    key_slot;
   logic [hsa_pkg::SLOT_W-1:0]    upper_slot;
   logic [31:0]                   full_handle;
   logic                          lookup_hit;
   logic                          store_commit;

   assign rd_entry     = hsa_pkg::entry_type'(ram_rd_data);
   assign size_mask    = ~({hsa_pkg::SLOT_W{1'b1}} << size_log2_ff);
   assign size_cnt     = hsa_pkg::CNT_W'(1) << size_log2_ff;
   assign probe_slot   = hsa_pkg::SLOT_W'(cand_ff) & size_mask;
   assign key_slot     = key_ff[hsa_pkg::SLOT_W-1:0] & size_mask;
   assign upper_slot   = idx_ff | hsa_pkg::SLOT_W'(size_cnt);
   assign full_handle  = 32'(cand_ff) | harbor_ff;
   assign lookup_hit   = rd_entry.valid && (rd_entry.handle == key_ff);
   assign store_commit = cmd.wr_en && (cmd.wr_sel == hsa_pkg::WR_STORE);

   // Status back to the controller
   always_comb begin
      status.op_lookup      = op_ff;
      status.count_full     = (entry_count_ff == size_cnt);
      status.grow_ok        = (32'(size_log2_ff) < 32'(hsa_pkg::LIMIT_LOG2));
      status.slot_free      = !rd_entry.valid;
      status.move_bit       = rd_entry.valid && 1'(rd_entry.handle >> size_log2_ff);
      status.idx_last_grow  = (idx_ff == size_mask);
      status.idx_last_clear = &idx_ff;
      status.out_free       = !rsp_valid_ff || !rsp_stall;
   end

   // Store read address
   always_comb begin
      case (cmd.rd_sel)
         hsa_pkg::RD_PROBE:  ram_rd_addr = probe_slot;
         hsa_pkg::RD_LOOKUP: ram_rd_addr = key_slot;
         hsa_pkg::RD_GROW:   ram_rd_addr = idx_ff;
         default:            ram_rd_addr = idx_ff;
      endcase
   end

   // Store write address and data
   always_comb begin
      ram_wr_en = cmd.wr_en;
      case (cmd.wr_sel)
         hsa_pkg::WR_ZERO: begin
            ram_wr_addr  = idx_ff;
            ram_wr_entry = '0;
         end
         hsa_pkg::WR_STORE: begin
            ram_wr_addr         = probe_slot;
            ram_wr_entry.valid  = 1'b1;
            ram_wr_entry.handle = full_handle;
            ram_wr_entry.ctx    = hsa_pkg::CONTEXT_BITS'(ctx_ff);
         end
         hsa_pkg::WR_MOVE: begin
            ram_wr_addr  = upper_slot;
            ram_wr_entry = rd_entry;
         end
         default: begin
            ram_wr_addr  = idx_ff;
            ram_wr_entry = '0;
         end
      endcase
   end

   hsa_ram #(
      .WIDTH (hsa_pkg::ENTRY_W),
      .DEPTH (hsa_pkg::SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (cmd.rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Table state updates
   always_comb begin
      harbor_in      = harbor_we ? csr_harbor : harbor_ff;
      size_log2_in   = cmd.grow_size ? size_log2_ff + hsa_pkg::LOG_W'(1) : size_log2_ff;
      next_index_in  = store_commit ? hsa_pkg::NEXT_W'(cand_ff) + hsa_pkg::NEXT_W'(1)
                                    : next_index_ff;
      entry_count_in = store_commit ? entry_count_ff + hsa_pkg::CNT_W'(1) : entry_count_ff;
      idx_in         = idx_ff;
      if (cmd.idx_clr) idx_in = '0;
      else if (cmd.idx_inc) idx_in = idx_ff + hsa_pkg::SLOT_W'(1);
   end

   // Item capture and probe candidate
   always_comb begin
      op_in   = op_ff;
      ctx_in  = ctx_ff;
      key_in  = key_ff;
      cand_in = cand_ff;
      if (cmd.load_item) begin
         op_in   = req_operation;
         ctx_in  = req_context_id;
         key_in  = req_handle;
         cand_in = hsa_pkg::HANDLE_BITS'(next_index_ff);
      end else if (cmd.cand_next) begin
         cand_in = cand_ff + hsa_pkg::HANDLE_BITS'(1);
      end
   end

   // Pending result
   always_comb begin
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      res_ctx_in    = res_ctx_ff;
      case (cmd.res_kind)
         hsa_pkg::RES_ISSUED: begin
            res_status_in = hsa_pkg::STATUS_OK;
            res_handle_in = full_handle;
            res_ctx_in    = '0;
         end
         hsa_pkg::RES_LOOKUP: begin
            res_status_in = lookup_hit ? hsa_pkg::STATUS_OK : hsa_pkg::STATUS_MISS;
            res_handle_in = '0;
            res_ctx_in    = lookup_hit ? 16'(rd_entry.ctx) : 16'd0;
         end
         hsa_pkg::RES_FULL: begin
            res_status_in = hsa_pkg::STATUS_FULL;
            res_handle_in = '0;
            res_ctx_in    = '0;
         end
         default: ;
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in  = cmd.out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_status_in = cmd.out_load ? res_status_ff : rsp_status_ff;
      rsp_handle_in = cmd.out_load ? res_handle_ff : rsp_handle_ff;
      rsp_ctx_in    = cmd.out_load ? res_ctx_ff    : rsp_ctx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         harbor_ff      <= '0;
         size_log2_ff   <= hsa_pkg::LOG_W'(hsa_pkg::INIT_LOG2);
         next_index_ff  <= '0;
         entry_count_ff <= '0;
         idx_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         harbor_ff      <= harbor_in;
         size_log2_ff   <= size_log2_in;
         next_index_ff  <= next_index_in;
         entry_count_ff <= entry_count_in;
         idx_ff         <= idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      ctx_ff        <= ctx_in;
      key_ff        <= key_in;
      cand_ff       <= cand_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      res_ctx_ff    <= res_ctx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_ctx_ff    <= rsp_ctx_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_issued_handle = rsp_handle_ff;
   assign rsp_found_context = rsp_ctx_ff;

endmodule

[rtl/hsa_ctrl.sv]
// Controller: sequences clearing, lookup, probing and in-place growth of the slot store.
module hsa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  hsa_pkg::status_type status,
   output hsa_pkg::cmd_type    cmd
);

   typedef enum logic [9:0] {
      ST_CLEAR     = 10'b0000000001,
      ST_IDLE      = 10'b0000000010,
      ST_DISPATCH  = 10'b0000000100,
      ST_LOOKUP    = 10'b0000001000,
      ST_PROBE_RD  = 10'b0000010000,
      ST_PROBE_CHK = 10'b0000100000,
      ST_GROW_RD   = 10'b0001000000,
      ST_GROW_CHK  = 10'b0010000000,
      ST_GROW_CLR  = 10'b0100000000,
      ST_FINISH    = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.rd_sel    = hsa_pkg::RD_PROBE;
      cmd.wr_sel    = hsa_pkg::WR_ZERO;
      cmd.res_kind  = hsa_pkg::RES_NONE;
      case (state_ff)
         // zero every slot after reset
         ST_CLEAR: begin
            cmd.wr_en   = 1'b1;
            cmd.idx_inc = 1'b1;
            if (status.idx_last_clear) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.op_lookup) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = hsa_pkg::RD_LOOKUP;
               state_in   = ST_LOOKUP;
            end else if (!status.count_full) begin
               cmd.rd_en = 1'b1;
               state_in  = ST_PROBE_CHK;
            end else if (status.grow_ok) begin
               cmd.idx_clr = 1'b1;
               state_in    = ST_GROW_RD;
            end else begin
               cmd.res_kind = hsa_pkg::RES_FULL;
               state_in     = ST_FINISH;
            end
         end
         ST_LOOKUP: begin
            cmd.res_kind = hsa_pkg::RES_LOOKUP;
            state_in     = ST_FINISH;
         end
         ST_PROBE_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_PROBE_CHK;
         end
         // first free slot takes the item, otherwise try the next handle
         ST_PROBE_CHK: begin
            if (status.slot_free) begin
               cmd.wr_en    = 1'b1;
               cmd.wr_sel   = hsa_pkg::WR_STORE;
               cmd.res_kind = hsa_pkg::RES_ISSUED;
               state_in     = ST_FINISH;
            end else begin
               cmd.cand_next = 1'b1;
               state_in      = ST_PROBE_RD;
            end
         end
         ST_GROW_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = hsa_pkg::RD_GROW;
            state_in   = ST_GROW_CHK;
         end
         // entry with the new size bit set moves to the upper half
         ST_GROW_CHK: begin
            if (status.move_bit) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = hsa_pkg::WR_MOVE;
               state_in   = ST_GROW_CLR;
            end else if (status.idx_last_grow) begin
               cmd.grow_size = 1'b1;
               state_in      = ST_PROBE_RD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_GROW_RD;
            end
         end
         ST_GROW_CLR: begin
            cmd.wr_en = 1'b1;
            if (status.idx_last_grow) begin
               cmd.grow_size = 1'b1;
               state_in      = ST_PROBE_RD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_GROW_RD;
            end
         end
         // hand the result over once the output register is free
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

endmodule
